@@ hdl/keypad_row_scan_event_detector_core_assert.svh @@
// ----------------------------------------------------------------------------
// keypad_row_scan_event_detector_core_assert
// Assertion macros for the keypad row scanner.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_ROW_SCAN_EVENT_DETECTOR_CORE_ASSERT_SVH
`define KEYPAD_ROW_SCAN_EVENT_DETECTOR_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define KPRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kprs: same-cycle check failed");

// next-cycle implication, disabled during reset
`define KPRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kprs: next-cycle check failed");

`endif

@@ hdl/kprs_pkg.sv @@
// ----------------------------------------------------------------------------
// kprs_pkg
// Types and constants shared by the keypad row scanner modules.
// ----------------------------------------------------------------------------
package kprs_pkg;

  localparam int MAX_ROWS_DEF = 4;

  localparam logic [1:0] OP_SCAN = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [1:0] CFG_LONG_TIMEOUT = 2'd1;

  localparam logic [2:0]  ROW_COUNT_RST    = 3'd4;
  localparam logic [15:0] LONG_TIMEOUT_RST = 16'd1000;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_PRESS   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_LONG    = 2'd3
  } action_t;

  typedef struct packed {
    logic [3:0] row_drive;
    logic       has_event;
    action_t    action;
    logic [7:0] key_code;
    logic [2:0] scan_row;
  } result_t;

endpackage

@@ hdl/kprs_state.sv @@
// ----------------------------------------------------------------------------
// kprs_state
// Scanner state registers and the single-pass update for one word.
// ----------------------------------------------------------------------------
module kprs_state
  import kprs_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [1:0]  op,
  input  logic [3:0]  row_levels,
  input  logic [2:0]  row_count,
  input  logic [15:0] long_timeout,
  output result_t     res
);

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  first_code_r, first_code_nxt;
  logic [7:0]  current_code_r, current_code_nxt;
  logic [7:0]  previous_code_r, previous_code_nxt;
  logic [7:0]  released_code_r, released_code_nxt;
  action_t     last_action_r, last_action_nxt;
  logic        event_pending_r, event_pending_nxt;
  logic [31:0] now_ms_r, now_ms_nxt;
  logic [31:0] press_ms_r, press_ms_nxt;

  logic [2:0]  rc;
  logic [2:0]  phase_c;
  logic [3:0]  row_mask;
  logic [3:0]  pressed;
  logic [7:0]  code;
  logic [7:0]  idle_code;
  logic [7:0]  cur;
  logic [31:0] held_ms;
  logic [7:0]  key;
  logic [2:0]  ph_o;

  always_comb begin
    if (row_count < 3'd3) begin
      rc = 3'd3;
    end else if (row_count > 3'(MAX_ROWS)) begin
      rc = 3'(MAX_ROWS);
    end else begin
      rc = row_count;
    end
  end

  // phase past the row count (row count shrank mid-scan) acts as idle phase
  assign phase_c  = (phase_r > rc) ? rc : phase_r;
  assign row_mask = 4'((5'd1 << rc) - 5'd1);
  assign pressed  = ~row_levels & row_mask & ~(4'((5'd1 << phase_c)));
  assign code     = 8'({4'b0000, pressed} << phase_c) + {5'b00000, phase_c};
  assign held_ms  = now_ms_r - press_ms_r;

  always_comb begin
    phase_nxt         = phase_r;
    first_code_nxt    = first_code_r;
    current_code_nxt  = current_code_r;
    previous_code_nxt = previous_code_r;
    released_code_nxt = released_code_r;
    last_action_nxt   = last_action_r;
    event_pending_nxt = event_pending_r;
    now_ms_nxt        = now_ms_r;
    press_ms_nxt      = press_ms_r;
    idle_code         = 8'd0;
    cur               = 8'd0;
    key               = 8'd0;
    case (op)
      OP_SCAN: begin
        if (pressed != 4'd0 && phase_c == rc) begin
          idle_code = code;
        end else if (pressed != 4'd0 && first_code_r == 8'd0) begin
          first_code_nxt = code;
        end
        if (phase_c == rc) begin
          phase_nxt        = 3'd0;
          cur              = (idle_code != 8'd0) ? idle_code : first_code_nxt;
          current_code_nxt = cur;
          first_code_nxt   = 8'd0;
          // resolve
          if (previous_code_r != cur && !event_pending_r) begin
            if (previous_code_r == 8'd0 && cur != 8'd0) begin
              last_action_nxt = ACT_PRESS;
            end else if (cur == 8'd0 && previous_code_r != 8'd0) begin
              last_action_nxt = ACT_RELEASE;
            end else begin
              last_action_nxt = ACT_NONE;
            end
            if (last_action_nxt != ACT_NONE) begin
              released_code_nxt = (last_action_nxt == ACT_RELEASE) ? previous_code_r : 8'd0;
              event_pending_nxt = 1'b1;
              previous_code_nxt = cur;
              press_ms_nxt      = now_ms_r;
            end
          end else if (cur != 8'd0 && previous_code_r == cur && !event_pending_r &&
                       last_action_r != ACT_LONG &&
                       held_ms > {16'd0, long_timeout}) begin
            last_action_nxt   = ACT_LONG;
            event_pending_nxt = 1'b1;
          end
        end else begin
          phase_nxt = phase_c + 3'd1;
        end
      end
      OP_TICK: begin
        now_ms_nxt = now_ms_r + 32'd1;
      end
      OP_READ: begin
        key = (last_action_r == ACT_RELEASE) ? released_code_r : current_code_r;
        event_pending_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign ph_o = (phase_nxt > rc) ? rc : phase_nxt;

  always_comb begin
    res.row_drive = (ph_o < rc) ? 4'((5'd1 << ph_o)) : 4'd0;
    res.has_event = event_pending_nxt;
    res.action    = last_action_nxt;
    res.key_code  = key;
    res.scan_row  = ph_o;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= 3'd0;
      first_code_r    <= 8'd0;
      current_code_r  <= 8'd0;
      previous_code_r <= 8'd0;
      released_code_r <= 8'd0;
      last_action_r   <= ACT_NONE;
      event_pending_r <= 1'b0;
      now_ms_r        <= 32'd0;
      press_ms_r      <= 32'd0;
    end else if (step_en) begin
      phase_r         <= phase_nxt;
      first_code_r    <= first_code_nxt;
      current_code_r  <= current_code_nxt;
      previous_code_r <= previous_code_nxt;
      released_code_r <= released_code_nxt;
      last_action_r   <= last_action_nxt;
      event_pending_r <= event_pending_nxt;
      now_ms_r        <= now_ms_nxt;
      press_ms_r      <= press_ms_nxt;
    end
  end

endmodule

@@ hdl/keypad_row_scan_event_detector_core.sv @@
// ----------------------------------------------------------------------------
// keypad_row_scan_event_detector_core
// Matrix keypad row scanner with pressed, released and long-press events.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | in_op, in_row_levels
//  out     | out_valid/out_stall| out_row_drive, out_has_event, out_action,
//          |                    | out_key_code, out_scan_row
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word per cycle sustained while the output is not stalled; a word goes
// from the input register to the result register, state updated as it moves.
// A stalled result holds the result register; an empty input register still
// takes one more word, after which in_stall rises.
// Synchronous active-low reset clears all scan state and restores defaults.
// ----------------------------------------------------------------------------
module keypad_row_scan_event_detector_core
  import kprs_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_row_levels,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_row_drive,
  output logic        out_has_event,
  output logic [1:0]  out_action,
  output logic [7:0]  out_key_code,
  output logic [2:0]  out_scan_row,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

`include "keypad_row_scan_event_detector_core_assert.svh"

  logic [2:0]  row_count_r;
  logic [15:0] long_timeout_r;

  logic        in_vld_r;
  logic [1:0]  in_op_r;
  logic [3:0]  in_levels_r;
  logic        out_vld_r;
  result_t     out_r;
  result_t     res;
  logic        adv;
  logic        in_take;
  logic        read_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= ROW_COUNT_RST;
      long_timeout_r <= LONG_TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROW_COUNT:    row_count_r    <= cfg_data[2:0];
        CFG_LONG_TIMEOUT: long_timeout_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_vld_r || adv) begin
      in_vld_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_op_r     <= in_op;
      in_levels_r <= in_row_levels;
    end
  end

  kprs_state #(
    .MAX_ROWS(MAX_ROWS)
  ) u_state (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (adv && in_vld_r),
    .op           (in_op_r),
    .row_levels   (in_levels_r),
    .row_count    (row_count_r),
    .long_timeout (long_timeout_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_vld_r) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_row_drive = out_r.row_drive;
  assign out_has_event = out_r.has_event;
  assign out_action    = out_r.action;
  assign out_key_code  = out_r.key_code;
  assign out_scan_row  = out_r.scan_row;

  assign read_step = adv && in_vld_r && in_op_r == OP_READ;

  `KPRS_ASSERT_NOW(a_row_drive_onehot, clk, rst_n, out_vld_r, $onehot0(out_r.row_drive))
  `KPRS_ASSERT_NOW(a_scan_row_range, clk, rst_n, out_vld_r, out_r.scan_row <= 3'(MAX_ROWS))
  `KPRS_ASSERT_NEXT(a_read_clears, clk, rst_n, read_step, out_vld_r && !out_r.has_event)
  `KPRS_ASSERT_NEXT(a_drain, clk, rst_n, out_vld_r && !out_stall && !in_vld_r, !out_vld_r)

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the keypad row scanner: every accepted word runs through a local
// scanner model, and each result word is compared field by field with the
// oldest predicted report. Directed tests go first, then random key traffic
// under several row-count and hold-time settings. Both sides idle and stall
// at random.
// ----------------------------------------------------------------------------
module testbench;
  import kprs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_WORDS = 1750;

  typedef enum int unsigned {
    HOLD_NONE, HOLD_MATRIX, HOLD_GROUND, HOLD_ALL_LOW, HOLD_NOISE
  } hold_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = OP_SCAN;
  logic [3:0]  in_row_levels = 4'hF;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_row_drive;
  logic        out_has_event;
  logic [1:0]  out_action;
  logic [7:0]  out_key_code;
  logic [2:0]  out_scan_row;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_ROW_COUNT;
  logic [15:0] cfg_data = 16'd0;

  keypad_row_scan_event_detector_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_row_levels (in_row_levels),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row_drive (out_row_drive),
    .out_has_event (out_has_event),
    .out_action    (out_action),
    .out_key_code  (out_key_code),
    .out_scan_row  (out_scan_row),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // scanner model state
  bit [2:0]  cfg_rows = ROW_COUNT_RST;
  bit [15:0] cfg_hold_ms = LONG_TIMEOUT_RST;
  bit [2:0]  sc_phase = '0;
  bit [7:0]  sc_first = '0;
  bit [7:0]  sc_current = '0;
  bit [7:0]  sc_previous = '0;
  bit [7:0]  sc_released = '0;
  action_t   sc_action = ACT_NONE;
  bit        sc_pending = 1'b0;
  bit [31:0] sc_now = '0;
  bit [31:0] sc_press = '0;

  result_t     reports_due[$];
  result_t     due_word;
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;

  // receiver stall pattern
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int unsigned rows_in_use();
    if (cfg_rows < 3) return 3;
    if (cfg_rows > MAX_ROWS_DEF) return MAX_ROWS_DEF;
    return cfg_rows;
  endfunction

  task automatic resolve_key();
    action_t act;
    if (sc_previous != sc_current && !sc_pending) begin
      if (sc_previous == 0 && sc_current != 0) act = ACT_PRESS;
      else if (sc_current == 0 && sc_previous != 0) act = ACT_RELEASE;
      else act = ACT_NONE;
      sc_action = act;
      if (act != ACT_NONE) begin
        sc_released = (act == ACT_RELEASE) ? sc_previous : 8'd0;
        sc_pending = 1'b1;
        sc_previous = sc_current;
        sc_press = sc_now;
      end
    end else if (sc_current != 0 && sc_previous == sc_current && !sc_pending &&
                 sc_action != ACT_LONG && (sc_now - sc_press) > 32'(cfg_hold_ms)) begin
      sc_action = ACT_LONG;
      sc_pending = 1'b1;
    end
  endtask

  task automatic scan_sample(bit [3:0] lv);
    int unsigned rc;
    bit [3:0] pressed;
    bit [7:0] code;
    bit [7:0] idle_code;
    rc = rows_in_use();
    idle_code = '0;
    if (sc_phase > rc) sc_phase = 3'(rc);
    pressed = ~lv & (4'hF >> (4 - rc));
    pressed &= ~(4'b1 << sc_phase);
    code = ({4'd0, pressed} << sc_phase) + 8'(sc_phase);
    if (pressed != 0 && sc_phase == rc) idle_code = code;
    else if (pressed != 0 && sc_first == 0) sc_first = code;
    sc_phase++;
    if (sc_phase > rc) begin
      sc_phase = '0;
      sc_current = (idle_code != 0) ? idle_code : sc_first;
      sc_first = '0;
      resolve_key();
    end
  endtask

  task automatic advance_scanner(bit [1:0] op, bit [3:0] lv, output result_t r);
    bit [7:0] key;
    int unsigned rc;
    bit [2:0] ph;
    key = '0;
    case (op)
      OP_SCAN: scan_sample(lv);
      OP_TICK: sc_now++;
      OP_READ: begin
        key = (sc_action == ACT_RELEASE) ? sc_released : sc_current;
        sc_pending = 1'b0;
      end
      default: ;
    endcase
    rc = rows_in_use();
    ph = (sc_phase > rc) ? 3'(rc) : sc_phase;
    r.row_drive = (ph < rc) ? (4'b1 << ph) : 4'b0;
    r.has_event = sc_pending;
    r.action = sc_action;
    r.key_code = key;
    r.scan_row = ph;
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0h, expected %0h (word %0d)", what, got, want,
             words_sent);
    mismatches++;
  endtask

  // sender: bursts of random length with random gaps
  task automatic send_word(logic [1:0] op, logic [3:0] lv);
    result_t r;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_op = op;
    in_row_levels = lv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_scanner(op, lv, r);
    reports_due.push_back(r);
    words_sent++;
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    pause_until_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ROW_COUNT:    cfg_rows = data[2:0];
      CFG_LONG_TIMEOUT: cfg_hold_ms = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one full pass over the rows plus the idle phase, levels set by the held key
  task automatic scan_frame(hold_kind_t kind, int unsigned drv, int unsigned sense);
    int unsigned rc;
    bit [2:0] ph;
    bit [3:0] lv;
    do begin
      rc = rows_in_use();
      ph = (sc_phase > rc) ? 3'(rc) : sc_phase;
      lv = 4'hF;
      case (kind)
        HOLD_MATRIX:  if (ph == drv) lv[sense] = 1'b0;
        HOLD_GROUND:  lv[sense] = 1'b0;
        HOLD_ALL_LOW: lv = 4'h0;
        HOLD_NOISE:   lv = 4'($urandom);
        default: ;
      endcase
      send_word(OP_SCAN, lv);
    end while (sc_phase != 0);
  endtask

  // receiver: own stall pattern, plus long hold-offs on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall = 1'b0;
    end else if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = $urandom_range(50, 80);
      out_stall = 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      case (stall_mode)
        0: out_stall = 1'b0;
        1: out_stall = ($urandom_range(0, 3) == 0);
        2: out_stall = 1'($urandom_range(0, 1));
        default: out_stall = (mode_left % 7 < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (reports_due.size() == 0) begin
        report_mismatch("unexpected word", out_key_code, 0);
      end else begin
        due_word = reports_due.pop_front();
        if (out_row_drive !== due_word.row_drive)
          report_mismatch("row_drive", out_row_drive, due_word.row_drive);
        if (out_has_event !== due_word.has_event)
          report_mismatch("has_event", out_has_event, due_word.has_event);
        if (out_action !== due_word.action)
          report_mismatch("action", out_action, due_word.action);
        if (out_key_code !== due_word.key_code)
          report_mismatch("key_code", out_key_code, due_word.key_code);
        if (out_scan_row !== due_word.scan_row)
          report_mismatch("scan_row", out_scan_row, due_word.scan_row);
      end
    end
  end

  task automatic test_idle_reads();
    send_word(OP_READ, 4'hF);
    send_word(OP_SPARE, 4'h0);
    scan_frame(HOLD_NONE, 0, 0);
  endtask

  // press, then a different code while the press is still unread, then read, release, read
  task automatic test_press_release();
    scan_frame(HOLD_MATRIX, 0, 1);
    scan_frame(HOLD_GROUND, 0, 2);
    send_word(OP_READ, 4'h5);
    scan_frame(HOLD_NONE, 0, 0);
    send_word(OP_READ, 4'hA);
  endtask

  // row count 0 saturates to three rows; one key replaced by another
  task automatic test_key_change();
    write_reg(CFG_ROW_COUNT, 16'h0000);
    scan_frame(HOLD_MATRIX, 1, 0);
    send_word(OP_READ, 4'hF);
    scan_frame(HOLD_ALL_LOW, 0, 0);
    send_word(OP_READ, 4'hF);
  endtask

  task automatic test_long_press();
    write_reg(CFG_LONG_TIMEOUT, 16'h0000);
    scan_frame(HOLD_NONE, 0, 0);
    send_word(OP_READ, 4'hF);
    scan_frame(HOLD_MATRIX, 2, 1);
    send_word(OP_READ, 4'hF);
    send_word(OP_TICK, 4'hF);
    scan_frame(HOLD_MATRIX, 2, 1);
    send_word(OP_READ, 4'hF);
    write_reg(CFG_LONG_TIMEOUT, 16'hFFFF);
  endtask

  // shrink the row count while the scan sits in the four-row idle phase
  task automatic test_row_count_limits();
    write_reg(CFG_ROW_COUNT, 16'hFFFF);
    while (sc_phase != 3'd4) send_word(OP_SCAN, 4'hF);
    write_reg(CFG_ROW_COUNT, 16'h0003);
    send_word(OP_READ, 4'hF);
    scan_frame(HOLD_GROUND, 0, 3);
    write_reg(REG_SPARE_2, 16'hFFFF);
    write_reg(REG_SPARE_3, 16'h0000);
    write_reg(CFG_ROW_COUNT, 16'(ROW_COUNT_RST));
    write_reg(CFG_LONG_TIMEOUT, LONG_TIMEOUT_RST);
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    gaps_on = 1'b0;
    burst_left = 0;
    hold_requests++;
    repeat (40) send_word(2'($urandom_range(0, 2)), 4'($urandom));
    pause_until_drained();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    int unsigned setting;
    int unsigned pick;
    int unsigned tick_max;
    int unsigned drv;
    int unsigned sense;
    hold_kind_t  kind;
    stop_at = words_sent + RANDOM_WORDS;
    setting = 0;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 7);
      if (pick < 3)
        write_reg(CFG_ROW_COUNT, {13'($urandom), 3'd3});
      else if (pick < 6)
        write_reg(CFG_ROW_COUNT, {13'($urandom), 3'd4});
      else
        write_reg(CFG_ROW_COUNT, 16'($urandom));
      case (setting % 5)
        0: write_reg(CFG_LONG_TIMEOUT, 16'($urandom_range(0, 3)));
        3: write_reg(CFG_LONG_TIMEOUT, 16'($urandom_range(1000, 65535)));
        default: write_reg(CFG_LONG_TIMEOUT, 16'($urandom_range(0, 40)));
      endcase
      if ($urandom_range(0, 4) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 16'($urandom));
      setting++;
      tick_max = (cfg_hold_ms <= 40) ? cfg_hold_ms / 3 + 1 : 3;
      repeat (10) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) kind = HOLD_NONE;
        else if (pick < 6) kind = HOLD_MATRIX;
        else if (pick < 8) kind = HOLD_GROUND;
        else if (pick < 9) kind = HOLD_ALL_LOW;
        else kind = HOLD_NOISE;
        drv = $urandom_range(0, 3);
        sense = $urandom_range(0, 3);
        repeat ($urandom_range(1, 4)) begin
          scan_frame(kind, drv, sense);
          repeat ($urandom_range(0, tick_max)) send_word(OP_TICK, 4'($urandom));
          if ($urandom_range(0, 1)) send_word(OP_READ, 4'($urandom));
          if ($urandom_range(0, 9) == 0) send_word(2'($urandom), 4'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_idle_reads();
    test_press_release();
    test_key_change();
    test_long_press();
    test_row_count_limits();
    test_backpressure();
    test_random_traffic();
    pause_until_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/kprs_pkg.sv
hdl/kprs_state.sv
hdl/keypad_row_scan_event_detector_core.sv
tb/testbench.sv
